/* hdl/qcer_pkg.sv */
// Shared types, constants and the quadrature decode table for the
// quadrature counter and echo ranger. No dependencies.
package qcer_pkg;

  // Field widths that the transaction format fixes.
  localparam int CHAN_W  = 2;
  localparam int CHAN_SPAN = 1 << CHAN_W;
  localparam int COUNT_W = 32;
  localparam int TIME_W  = 32;
  localparam int DIST_W  = 24;
  localparam int LIMIT_W = 16;

  // Range limit after reset, in millimeters.
  localparam logic [LIMIT_W-1:0] RANGE_RESET = 16'd4000;

  // Distance scaling: dist_q8 = floor(e * 1088 / 25) = 43 * e + floor(13 * e / 25).
  // An in-range elapsed time never exceeds 385500 us, which fits in 19 bits.
  localparam int ELAPSED_W = 19;
  localparam int Y_W       = 23;  // width of 13 * e
  localparam int RECIP_W   = 24;
  localparam int RECIP_SH  = 28;
  localparam int PROD_W    = Y_W + RECIP_W;
  localparam int E43_W     = ELAPSED_W + 6;
  // ceil(2^28 / 25); exact quotient for every dividend below 2^23.
  localparam logic [RECIP_W-1:0] RECIP_M = 24'd10737419;
  localparam logic [DIST_W-1:0] Q8_FULL = 24'hFFFFFF;

  // Event kinds.
  localparam logic FUNC_ENCODER = 1'b0;
  localparam logic FUNC_ECHO    = 1'b1;

  // Echo levels.
  localparam logic ECHO_FALL = 1'b0;
  localparam logic ECHO_RISE = 1'b1;

  // Quadrature step codes.
  localparam logic [1:0] STEP_HOLD = 2'd0;
  localparam logic [1:0] STEP_FWD  = 2'd1;
  localparam logic [1:0] STEP_BACK = 2'd2;

  typedef struct packed {
    logic              func;
    logic [CHAN_W-1:0] channel;
    logic              phase_a;
    logic              phase_b;
    logic              echo_level;
    logic [TIME_W-1:0] time_us;
  } in_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] position_count;
    logic [DIST_W-1:0]         distance_q8;
    logic                      distance_valid;
    logic                      out_of_range;
  } out_t;

  // One entry of the per-channel state memory.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [1:0]         last_ph;
    logic [TIME_W-1:0]  start;
  } entry_t;

  // What the update stage hands to the distance scaler.
  typedef struct packed {
    logic                 chan_ok;
    logic [COUNT_W-1:0]   pos;
    logic                 dist_v;
    logic                 oor;
    logic [ELAPSED_W-1:0] elapsed;
  } scale_item_t;

  // Decode of {last A, last B, new A, new B} into a count step.
  function automatic logic [1:0] qcer_quad_step(input logic [3:0] idx);
    logic [1:0] step;
    case (idx)
      4'b1101, 4'b0100, 4'b0010, 4'b1011: step = STEP_FWD;
      4'b1110, 4'b0111, 4'b0001, 4'b1000: step = STEP_BACK;
      default:                            step = STEP_HOLD;
    endcase
    return step;
  endfunction

endpackage

/* hdl/qcer_state_ram.sv */
// Per-channel state memory with a registered read port, valid bits for the
// all-zero reset, and forwarding of the latest write. Depends on qcer_pkg.
module qcer_state_ram #(
  parameter int DEPTH = 4,
  parameter int IDX_W = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_idx,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  qcer_pkg::entry_t    wr_data,
  output qcer_pkg::entry_t    rd_entry
);
  import qcer_pkg::*;

  entry_t             mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  entry_t             rd_data_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               fwd_v_r;
  logic [IDX_W-1:0]   fwd_idx_r;
  entry_t             fwd_data_r;

  // Storage array: write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
      rd_idx_r  <= rd_idx;
    end
    if (wr_en) begin
      fwd_idx_r  <= wr_idx;
      fwd_data_r <= wr_data;
    end
  end

  // Entry valid bits and the forwarding tag; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      fwd_v_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
        fwd_v_r       <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  // The latest write wins over the array, since a read issued on the same edge
  // as a write to that entry returns the old contents.
  always_comb begin
    if (fwd_v_r && (fwd_idx_r == rd_idx_r)) begin
      rd_entry = fwd_data_r;
    end else if (rd_vld_r) begin
      rd_entry = rd_data_r;
    end else begin
      rd_entry = '0;
    end
  end

endmodule

/* hdl/qcer_scale.sv */
// Two-stage distance scaler: reciprocal multiply, then the final add and the
// result format. Depends on qcer_pkg.
module qcer_scale (
  input  logic                   clk,
  input  logic                   s2_load,
  input  qcer_pkg::scale_item_t  s2_item,
  input  logic                   out_load,
  output qcer_pkg::out_t         out_data
);
  import qcer_pkg::*;

  scale_item_t        item_r;
  logic [PROD_W-1:0]  prod_r;
  logic [E43_W-1:0]   e43_r;
  out_t               out_data_r;

  logic [Y_W-1:0]     y;
  logic [E43_W-1:0]   e43;
  logic [E43_W-1:0]   sum;
  logic [ELAPSED_W-1:0] quo;
  out_t               out_nxt;

  // 13 * e and 43 * e by shift and add.
  always_comb begin
    y   = ({4'd0, s2_item.elapsed} << 3) + ({4'd0, s2_item.elapsed} << 2)
        + {4'd0, s2_item.elapsed};
    e43 = ({6'd0, s2_item.elapsed} << 5) + ({6'd0, s2_item.elapsed} << 3)
        + ({6'd0, s2_item.elapsed} << 1) + {6'd0, s2_item.elapsed};
  end

  // Multiply stage: floor(13 * e / 25) through the reciprocal.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      item_r <= s2_item;
      prod_r <= PROD_W'(y) * PROD_W'(RECIP_M);
      e43_r  <= e43;
    end
  end

  // Final add and result selection.
  always_comb begin
    quo = prod_r[RECIP_SH +: ELAPSED_W];
    sum = e43_r + {{(E43_W-ELAPSED_W){1'b0}}, quo};
    out_nxt = '0;
    if (item_r.chan_ok) begin
      out_nxt.position_count = item_r.pos;
      out_nxt.distance_valid = item_r.dist_v;
      out_nxt.out_of_range   = item_r.oor;
      if (!item_r.dist_v) begin
        out_nxt.distance_q8 = '0;
      end else if (item_r.oor) begin
        out_nxt.distance_q8 = Q8_FULL;
      end else begin
        out_nxt.distance_q8 = sum[DIST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

/* hdl/quadrature_counter_echo_ranger.sv */
// Quadrature counter and echo ranger top level: handshake pipeline, state
// update and range register. Depends on qcer_pkg, qcer_state_ram, qcer_scale.
//
// Takes one event transaction per clock unless the output stalls, and returns
// exactly one result transaction for each, in order, through the update,
// multiply and output registers. Each event reads its channel's state entry
// in the cycle it is accepted, is updated and written back as it leaves the
// update stage, and its distance is scaled in the multiply and output stages;
// back-to-back events on the same channel see each other's writes through a
// one-entry forwarding path, so unstalled throughput is one event per cycle.
// Encoder events step the channel's 32-bit count by the quadrature table;
// echo rising edges store the timestamp, falling edges report the distance in
// millimeters with eight fraction bits, or full scale with out_of_range set
// above the range limit. Events for a channel at or above NUM_CHANNELS leave
// the state alone and return all-zero fields. The range limit is written
// through the cfg port, which is always ready.
module quadrature_counter_echo_ranger #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  qcer_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output qcer_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qcer_pkg::LIMIT_W-1:0]     cfg_data
);
  import qcer_pkg::*;

  localparam int DEPTH = (NUM_CHANNELS < CHAN_SPAN) ? NUM_CHANNELS : CHAN_SPAN;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic               s1_v_r, s2_v_r, out_v_r;
  in_t                s1_in_r;
  logic               s1_ok_r;
  logic [LIMIT_W-1:0] range_limit_r;

  logic               rdy_out, rdy2, rdy1;
  logic               in_acc;
  logic               in_ok;
  entry_t             cur;
  entry_t             upd;
  scale_item_t        s2_item;
  logic [1:0]         step;
  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W+4:0]  lhs;
  logic [22:0]        rhs;

  // Stage readiness: each register loads when it is empty or drains.
  assign rdy_out  = !out_v_r || !out_stall;
  assign rdy2     = !s2_v_r || rdy_out;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_stall = !rdy1;
  assign in_acc   = in_valid && rdy1;
  assign in_ok    = (32'(in_data.channel) < 32'(NUM_CHANNELS));
  assign cfg_ready = 1'b1;

  // Valid flags of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Update stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_in_r <= in_data;
      s1_ok_r <= in_ok;
    end
  end

  // Range limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_limit_r <= RANGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      range_limit_r <= cfg_data;
    end
  end

  qcer_state_ram #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_idx   (in_data.channel[IDX_W-1:0]),
    .wr_en    (s1_v_r && rdy2 && s1_ok_r),
    .wr_idx   (s1_in_r.channel[IDX_W-1:0]),
    .wr_data  (upd),
    .rd_entry (cur)
  );

  // Read-modify-write of the channel entry.
  always_comb begin
    step = qcer_quad_step({cur.last_ph, s1_in_r.phase_a, s1_in_r.phase_b});
    upd  = cur;
    if (s1_in_r.func == FUNC_ENCODER) begin
      upd.last_ph = {s1_in_r.phase_a, s1_in_r.phase_b};
      case (step)
        STEP_FWD:  upd.count = cur.count + 32'd1;
        STEP_BACK: upd.count = cur.count - 32'd1;
        default:   upd.count = cur.count;
      endcase
    end else if (s1_in_r.echo_level == ECHO_RISE) begin
      upd.start = s1_in_r.time_us;
    end
  end

  // Elapsed time and the exact range test: 17 * e > 100 * limit.
  always_comb begin
    elapsed = s1_in_r.time_us - cur.start;
    lhs = ({5'd0, elapsed} << 4) + {5'd0, elapsed};
    rhs = ({7'd0, range_limit_r} << 6) + ({7'd0, range_limit_r} << 5)
        + ({7'd0, range_limit_r} << 2);
    s2_item.chan_ok = s1_ok_r;
    s2_item.pos     = upd.count;
    s2_item.dist_v  = (s1_in_r.func == FUNC_ECHO) && (s1_in_r.echo_level == ECHO_FALL);
    s2_item.oor     = s2_item.dist_v && (lhs > {14'd0, rhs});
    s2_item.elapsed = elapsed[ELAPSED_W-1:0];
  end

  qcer_scale u_scale (
    .clk      (clk),
    .s2_load  (rdy2 && s1_v_r),
    .s2_item  (s2_item),
    .out_load (rdy_out && s2_v_r),
    .out_data (out_data)
  );

  assign out_valid = out_v_r;

endmodule

/* hdl/qcer_checker.sv */
// Port-level checks for the quadrature counter and echo ranger, and the bind
// that attaches them to the top level. Depends on qcer_pkg.
module qcer_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input qcer_pkg::out_t   out_data
);
  import qcer_pkg::*;

  // A stalled result transaction stays up unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // No result is presented in the first cycle after reset is released.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A result without a finished measurement carries no distance.
  a_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.distance_valid |->
      (out_data.distance_q8 == '0) && !out_data.out_of_range)
    else $error("distance reported without a measurement");

  // An out-of-range measurement reports full scale.
  a_oor_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |->
      out_data.distance_valid && (out_data.distance_q8 == Q8_FULL))
    else $error("out-of-range result not at full scale");

endmodule

bind quadrature_counter_echo_ranger qcer_checker u_qcer_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* bench/tb_quadrature_counter_echo_ranger.sv */
`timescale 1ns / 1ps
// Self-checking bench for quadrature_counter_echo_ranger: a queued event driver, a
// result monitor and a tracker of encoder counts and echo start times.
// Depends on qcer_pkg and the block's RTL.
module tb_quadrature_counter_echo_ranger;
  import qcer_pkg::*;

  localparam int NUM_CH = 4;
  localparam int IDLE_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int NUM_PHASES = 6;
  localparam int DRAIN_CYCLES = 8;

  // Sound travels 0.17 mm per microsecond; in Q8 that is 1088 / 25.
  localparam longint unsigned MM_NUM = 17;
  localparam longint unsigned MM_DEN = 100;
  localparam longint unsigned Q8_NUM = 1088;
  localparam longint unsigned Q8_DEN = 25;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  // Tracked block state and the range limit in force.
  logic [COUNT_W-1:0] enc_count [NUM_CH];
  logic [1:0]         enc_pair [NUM_CH];
  logic [TIME_W-1:0]  echo_t0 [NUM_CH];
  logic [LIMIT_W-1:0] limit_mm;

  // Generator view of each channel, kept ahead of the block.
  logic [1:0]         gen_pair [NUM_CH];
  logic [TIME_W-1:0]  gen_t0 [NUM_CH];
  logic               gen_armed [NUM_CH];
  logic [TIME_W-1:0]  gen_clock;

  in_t  event_queue [$];
  out_t expected_results [$];
  int   errors = 0;
  int   in_gap = 0;
  int   in_quiet = 0;
  int   out_hold = 0;
  int   out_quiet = 0;
  int   idle_cycles = 0;

  quadrature_counter_echo_ranger #(
    .NUM_CHANNELS(NUM_CH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Position of a phase pair along the forward cycle 00, 10, 11, 01.
  function automatic logic [1:0] wheel_pos(input logic [1:0] pair);
    return {pair[0], pair[1] ^ pair[0]};
  endfunction

  function automatic logic [1:0] pair_at(input logic [1:0] pos);
    return {pos[0] ^ pos[1], pos[1]};
  endfunction

  // Apply one event to the tracked state and return the result it should give.
  function automatic out_t track_event(input in_t ev);
    out_t              res;
    logic [1:0]        pair;
    logic [1:0]        moved;
    logic [TIME_W-1:0] elapsed;
    int unsigned       ch;
    res = '0;
    ch = ev.channel;
    if (ch < NUM_CH) begin
      if (ev.func == FUNC_ENCODER) begin
        pair = {ev.phase_a, ev.phase_b};
        moved = wheel_pos(pair) - wheel_pos(enc_pair[ch]);
        if (moved == 2'd1) begin
          enc_count[ch] = enc_count[ch] + 1'b1;
        end else if (moved == 2'd3) begin
          enc_count[ch] = enc_count[ch] - 1'b1;
        end
        enc_pair[ch] = pair;
      end else if (ev.echo_level == ECHO_RISE) begin
        echo_t0[ch] = ev.time_us;
      end else begin
        elapsed = ev.time_us - echo_t0[ch];
        res.distance_valid = 1'b1;
        if (64'(elapsed) * MM_NUM > 64'(limit_mm) * MM_DEN) begin
          res.out_of_range = 1'b1;
          res.distance_q8 = Q8_FULL;
        end else begin
          res.distance_q8 = DIST_W'(64'(elapsed) * Q8_NUM / Q8_DEN);
        end
      end
      res.position_count = enc_count[ch];
    end
    return res;
  endfunction

  // Queue an event and keep the generator's view of the channel in step.
  task automatic push_event(input in_t ev);
    if (ev.func == FUNC_ENCODER) begin
      gen_pair[ev.channel] = {ev.phase_a, ev.phase_b};
    end else if (ev.echo_level == ECHO_RISE) begin
      gen_t0[ev.channel] = ev.time_us;
      gen_armed[ev.channel] = 1'b1;
    end else begin
      gen_armed[ev.channel] = 1'b0;
    end
    event_queue.push_back(ev);
  endtask

  // Mostly encoder walks and rise/fall pairs, with some fully random noise.
  function automatic in_t make_event();
    in_t               ev;
    int unsigned       r;
    int unsigned       m;
    logic [1:0]        ch;
    logic [1:0]        pos;
    logic [TIME_W-1:0] bound;
    logic [TIME_W-1:0] elapsed;
    r = $urandom_range(0, 99);
    ch = 2'($urandom_range(0, NUM_CH - 1));
    ev.func = 1'($urandom);
    ev.channel = ch;
    ev.phase_a = 1'($urandom);
    ev.phase_b = 1'($urandom);
    ev.echo_level = 1'($urandom);
    ev.time_us = $urandom;
    if (r < 45) begin
      ev.func = FUNC_ENCODER;
      m = $urandom_range(0, 99);
      pos = wheel_pos(gen_pair[ch]);
      if (m < 40) begin
        {ev.phase_a, ev.phase_b} = pair_at(pos + 2'd1);
      end else if (m < 70) begin
        {ev.phase_a, ev.phase_b} = pair_at(pos - 2'd1);
      end else if (m < 82) begin
        {ev.phase_a, ev.phase_b} = gen_pair[ch];
      end else if (m < 92) begin
        {ev.phase_a, ev.phase_b} = pair_at(pos + 2'd2);
      end
    end else if (r < 90) begin
      ev.func = FUNC_ECHO;
      if (!gen_armed[ch]) begin
        if ($urandom_range(0, 19) == 0) begin
          gen_clock = $urandom;
        end else begin
          gen_clock = gen_clock + $urandom_range(1, 100000);
        end
        ev.echo_level = ECHO_RISE;
        ev.time_us = gen_clock;
      end else begin
        // Largest in-range elapsed time for the current limit.
        bound = TIME_W'(64'(limit_mm) * MM_DEN / MM_NUM);
        m = $urandom_range(0, 99);
        if (m < 35) begin
          elapsed = bound + $urandom_range(0, 6) - 3;
        end else if (m < 65) begin
          elapsed = $urandom_range(0, bound);
        end else if (m < 80) begin
          elapsed = $urandom_range(0, 50);
        end else if (m < 90) begin
          elapsed = $urandom;
        end else begin
          elapsed = '0;
        end
        ev.echo_level = ECHO_FALL;
        ev.time_us = gen_t0[ch] + elapsed;
      end
    end
    return ev;
  endfunction

  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic wait_drained();
    while (event_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_mm = value;
  endtask

  // Event driver: record each accepted transaction, then load the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(track_event(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (event_queue.size() != 0) begin
          in_data <= event_queue.pop_front();
          in_valid <= 1'b1;
          if (in_quiet != 0) begin
            in_quiet--;
          end else begin
            in_gap = idle_len();
            if ($urandom_range(0, 39) == 0) in_quiet = $urandom_range(20, 100);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted transaction with the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction arrived with none expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.position_count !== want.position_count) begin
            $error("position_count: expected %0d, got %0d",
                   want.position_count, out_data.position_count);
            errors++;
          end
          if (out_data.distance_q8 !== want.distance_q8) begin
            $error("distance_q8: expected 0x%06h, got 0x%06h",
                   want.distance_q8, out_data.distance_q8);
            errors++;
          end
          if (out_data.distance_valid !== want.distance_valid) begin
            $error("distance_valid: expected %0b, got %0b",
                   want.distance_valid, out_data.distance_valid);
            errors++;
          end
          if (out_data.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0b, got %0b",
                   want.out_of_range, out_data.out_of_range);
            errors++;
          end
        end
      end
      if (out_hold != 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
        if (out_quiet != 0) begin
          out_quiet--;
        end else begin
          out_hold = idle_len();
          if ($urandom_range(0, 39) == 0) out_quiet = $urandom_range(20, 100);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("quadrature_counter_echo_ranger regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [LIMIT_W-1:0] limits [NUM_PHASES];
    logic [TIME_W-1:0]  bound;
    for (int i = 0; i < NUM_CH; i++) begin
      enc_count[i] = '0;
      enc_pair[i] = '0;
      echo_t0[i] = '0;
      gen_pair[i] = '0;
      gen_t0[i] = '0;
      gen_armed[i] = 1'b0;
    end
    limit_mm = RANGE_RESET;
    gen_clock = $urandom;
    limits[0] = RANGE_RESET;
    limits[1] = '0;
    limits[2] = 16'd1;
    limits[3] = 16'hFFFF;
    limits[4] = 16'($urandom_range(2, 65534));
    limits[5] = RANGE_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset limit.
    bound = TIME_W'(64'(RANGE_RESET) * MM_DEN / MM_NUM);
    // Full forward turn, a step back, a hold and an illegal double step.
    push_event(in_t'{FUNC_ENCODER, 2'd0, 1'b1, 1'b0, 1'b0, 32'd0});
    push_event(in_t'{FUNC_ENCODER, 2'd0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF});
    push_event(in_t'{FUNC_ENCODER, 2'd0, 1'b0, 1'b1, 1'b0, 32'd0});
    push_event(in_t'{FUNC_ENCODER, 2'd0, 1'b0, 1'b0, 1'b1, 32'h5555_5555});
    push_event(in_t'{FUNC_ENCODER, 2'd0, 1'b0, 1'b1, 1'b0, 32'hAAAA_AAAA});
    push_event(in_t'{FUNC_ENCODER, 2'd0, 1'b0, 1'b1, 1'b0, 32'd0});
    push_event(in_t'{FUNC_ENCODER, 2'd0, 1'b1, 1'b0, 1'b0, 32'd0});
    // Counting backward from zero wraps to all ones.
    push_event(in_t'{FUNC_ENCODER, 2'd3, 1'b0, 1'b1, 1'b0, 32'd0});
    push_event(in_t'{FUNC_ENCODER, 2'd3, 1'b0, 1'b0, 1'b0, 32'd0});
    push_event(in_t'{FUNC_ENCODER, 2'd3, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF});
    // Falling edge with no prior start uses the reset start time.
    push_event(in_t'{FUNC_ECHO, 2'd2, 1'b1, 1'b1, ECHO_FALL, 32'd1000});
    // Elapsed time that wraps through zero.
    push_event(in_t'{FUNC_ECHO, 2'd1, 1'b1, 1'b0, ECHO_RISE, 32'hFFFF_FFF0});
    push_event(in_t'{FUNC_ECHO, 2'd1, 1'b0, 1'b1, ECHO_FALL, 32'h0000_0010});
    // Largest elapsed time is far out of range.
    push_event(in_t'{FUNC_ECHO, 2'd1, 1'b0, 1'b0, ECHO_RISE, 32'd0});
    push_event(in_t'{FUNC_ECHO, 2'd1, 1'b1, 1'b1, ECHO_FALL, 32'hFFFF_FFFF});
    // Zero elapsed time.
    push_event(in_t'{FUNC_ECHO, 2'd3, 1'b0, 1'b0, ECHO_RISE, 32'd5000});
    push_event(in_t'{FUNC_ECHO, 2'd3, 1'b0, 1'b0, ECHO_FALL, 32'd5000});
    // Just inside and just past the range limit, reusing one start time.
    push_event(in_t'{FUNC_ECHO, 2'd2, 1'b0, 1'b0, ECHO_RISE, 32'd100});
    push_event(in_t'{FUNC_ECHO, 2'd2, 1'b0, 1'b0, ECHO_FALL, 32'd100 + bound});
    push_event(in_t'{FUNC_ECHO, 2'd2, 1'b1, 1'b1, ECHO_FALL, 32'd101 + bound});
    // Echo events report the unchanged count of their channel.
    push_event(in_t'{FUNC_ECHO, 2'd0, 1'b1, 1'b1, ECHO_RISE, 32'h8000_0000});
    push_event(in_t'{FUNC_ECHO, 2'd0, 1'b0, 1'b0, ECHO_FALL, 32'h8000_1234});

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
        write_limit(limits[p]);
      end
      repeat (ITEMS_PER_PHASE) push_event(make_event());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("quadrature_counter_echo_ranger regression: pass");
    end else begin
      $display("quadrature_counter_echo_ranger regression: fail");
    end
    $finish;
  end

endmodule

/* quadrature_counter_echo_ranger.f */
hdl/qcer_pkg.sv
hdl/qcer_state_ram.sv
hdl/qcer_scale.sv
hdl/quadrature_counter_echo_ranger.sv
hdl/qcer_checker.sv
bench/tb_quadrature_counter_echo_ranger.sv
